### rtl/afit_pkg.sv
// Shared constants and types for the aspect-ratio fit scaler.
`timescale 1ns / 1ps

package afit_pkg;

	// Default dimension width in bits
	localparam int DIM_BITS_DEF = 16;

	// Carried through the divider stages; tells the output register which axis, if any, takes the quotient
	typedef struct packed {
		logic div_en;   // one axis is scaled by the quotient
		logic div_w;    // the scaled axis is the width (else the height)
	} afit_ctl_t;

endpackage

### rtl/aspect_fit_image_size.sv
// Top level of the aspect-ratio fit scaler.
//
// Usage: present a request on in_valid with orig_width, orig_height,
// box_width, box_height and mode; it is taken at a clock edge where
// in_valid is high and in_stall is low. Each request gives exactly one
// result on out_valid with fit_width and fit_height, taken where out_valid
// is high and out_stall is low. Results leave in request order.
// A request passes three setup stages (clamp, cross multiply, operand
// select), one divider stage per quotient bit, and the output register.
// One request is taken every cycle while out_stall is low; the rate is
// set by the per-stage handshake, each stage moving on when empty or when
// its successor moves. When out_stall is high the held result stays put
// and empty stages keep filling, so in_stall rises only once every stage
// holds a request. Reset clears all valid bits; the pipeline is empty and
// ready in the first cycle after arst_n goes high.
`timescale 1ns / 1ps

module aspect_fit_image_size
	import afit_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [DIM_BITS-1:0] orig_width,
	input  logic [DIM_BITS-1:0] orig_height,
	input  logic [DIM_BITS-1:0] box_width,
	input  logic [DIM_BITS-1:0] box_height,
	input  logic                mode,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DIM_BITS-1:0] fit_width,
	output logic [DIM_BITS-1:0] fit_height
);

	logic                  setup_ready, setup_valid;
	logic [2*DIM_BITS-1:0] setup_num;
	logic [DIM_BITS-1:0]   setup_den, setup_rw, setup_rh;
	afit_ctl_t             setup_ctl;

	logic                  div_ready, div_valid;
	logic [DIM_BITS-1:0]   div_quo, div_rw, div_rh;
	afit_ctl_t             div_ctl;

	logic                  out_en;
	logic                  out_valid_q;
	logic [DIM_BITS-1:0]   fit_width_q, fit_height_q;

	afit_setup #(.DIM_BITS(DIM_BITS)) u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (in_valid),
		.up_ready   (setup_ready),
		.orig_width (orig_width),
		.orig_height(orig_height),
		.box_width  (box_width),
		.box_height (box_height),
		.mode       (mode),
		.dn_valid   (setup_valid),
		.dn_ready   (div_ready),
		.num        (setup_num),
		.den        (setup_den),
		.rw_fix     (setup_rw),
		.rh_fix     (setup_rh),
		.ctl        (setup_ctl)
	);

	afit_div #(.DIM_BITS(DIM_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (setup_valid),
		.up_ready (div_ready),
		.num      (setup_num),
		.den      (setup_den),
		.rw_fix   (setup_rw),
		.rh_fix   (setup_rh),
		.ctl      (setup_ctl),
		.dn_valid (div_valid),
		.dn_ready (out_en),
		.quo      (div_quo),
		.rw_out   (div_rw),
		.rh_out   (div_rh),
		.ctl_out  (div_ctl)
	);

	assign in_stall = !setup_ready;

	// Output register: load when empty or when the held request is taken
	assign out_en = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= div_valid;
		end
	end

	// Put the quotient on the scaled axis, the fixed value on the other
	always_ff @(posedge clk) begin
		if (out_en && div_valid) begin
			fit_width_q  <= (div_ctl.div_en && div_ctl.div_w) ? div_quo : div_rw;
			fit_height_q <= (div_ctl.div_en && !div_ctl.div_w) ? div_quo : div_rh;
		end
	end

	assign out_valid  = out_valid_q;
	assign fit_width  = fit_width_q;
	assign fit_height = fit_height_q;

endmodule

### rtl/afit_setup.sv
// Front stages: classify and clamp, cross multiply, pick the divide operands.
`timescale 1ns / 1ps

module afit_setup
	import afit_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  logic [DIM_BITS-1:0]     orig_width,
	input  logic [DIM_BITS-1:0]     orig_height,
	input  logic [DIM_BITS-1:0]     box_width,
	input  logic [DIM_BITS-1:0]     box_height,
	input  logic                    mode,
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output logic [2*DIM_BITS-1:0]   num,
	output logic [DIM_BITS-1:0]     den,
	output logic [DIM_BITS-1:0]     rw_fix,
	output logic [DIM_BITS-1:0]     rh_fix,
	output afit_ctl_t               ctl
);

	localparam int PW = 2 * DIM_BITS;

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;

	logic                zero_c, fits_c;
	logic                zero_s1, byp_s1;
	logic [DIM_BITS-1:0] ow_s1, oh_s1, bw_s1, bh_s1;

	logic                zero_s2, byp_s2;
	logic [DIM_BITS-1:0] ow_s2, oh_s2, bw_s2, bh_s2;
	logic [PW-1:0]       cw_s2, ch_s2;

	logic                lt_c, eq_c;
	logic [PW-1:0]       num_s3;
	logic [DIM_BITS-1:0] den_s3, rw_s3, rh_s3;
	afit_ctl_t           ctl_s3;

	// Advance a stage when it is empty or its successor advances
	assign en3      = !v_s3 || dn_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign up_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= up_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Stage 1: flag zero and bypass cases, clamp the box when the image is larger
	assign zero_c = (orig_width == '0) || (orig_height == '0);
	assign fits_c = (orig_width <= box_width) && (orig_height <= box_height);

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			zero_s1 <= zero_c;
			byp_s1  <= fits_c && !mode;
			ow_s1   <= orig_width;
			oh_s1   <= orig_height;
			bw_s1   <= (!fits_c && (box_width > orig_width)) ? orig_width : box_width;
			bh_s1   <= (!fits_c && (box_height > orig_height)) ? orig_height : box_height;
		end
	end

	// Stage 2: cross products
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			zero_s2 <= zero_s1;
			byp_s2  <= byp_s1;
			ow_s2   <= ow_s1;
			oh_s2   <= oh_s1;
			bw_s2   <= bw_s1;
			bh_s2   <= bh_s1;
			cw_s2   <= PW'(ow_s1) * PW'(bh_s1);
			ch_s2   <= PW'(oh_s1) * PW'(bw_s1);
		end
	end

	// Stage 3: choose the limiting axis and form the rounded dividend
	assign lt_c = cw_s2 < ch_s2;
	assign eq_c = cw_s2 == ch_s2;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			num_s3        <= lt_c ? (cw_s2 + PW'(oh_s2 >> 1)) : (ch_s2 + PW'(ow_s2 >> 1));
			den_s3        <= lt_c ? oh_s2 : ow_s2;
			rw_s3         <= zero_s2 ? '0 : (byp_s2 ? ow_s2 : bw_s2);
			rh_s3         <= zero_s2 ? '0 : (byp_s2 ? oh_s2 : bh_s2);
			ctl_s3.div_en <= !zero_s2 && !byp_s2 && !eq_c;
			ctl_s3.div_w  <= lt_c;
		end
	end

	assign dn_valid = v_s3;
	assign num      = num_s3;
	assign den      = den_s3;
	assign rw_fix   = rw_s3;
	assign rh_fix   = rh_s3;
	assign ctl      = ctl_s3;

endmodule

### rtl/afit_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps

module afit_div
	import afit_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  logic [2*DIM_BITS-1:0]   num,
	input  logic [DIM_BITS-1:0]     den,
	input  logic [DIM_BITS-1:0]     rw_fix,
	input  logic [DIM_BITS-1:0]     rh_fix,
	input  afit_ctl_t               ctl,
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output logic [DIM_BITS-1:0]     quo,
	output logic [DIM_BITS-1:0]     rw_out,
	output logic [DIM_BITS-1:0]     rh_out,
	output afit_ctl_t               ctl_out
);

	localparam int N = DIM_BITS;

	// Index 0 is the stage input, index k+1 is the register of stage k
	logic            v   [0:N];
	logic            en  [0:N];
	logic [N-1:0]    rem [0:N];
	logic [N-1:0]    low [0:N];
	logic [N-1:0]    q   [0:N];
	logic [N-1:0]    dv  [0:N];
	logic [N-1:0]    rw  [0:N];
	logic [N-1:0]    rh  [0:N];
	afit_ctl_t       cc  [0:N];

	// The quotient fits N bits, so the upper dividend half is below the divisor
	assign v[0]   = up_valid;
	assign rem[0] = num[2*N-1:N];
	assign low[0] = num[N-1:0];
	assign q[0]   = '0;
	assign dv[0]  = den;
	assign rw[0]  = rw_fix;
	assign rh[0]  = rh_fix;
	assign cc[0]  = ctl;
	assign en[N]  = dn_ready;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic         v_s;
		logic [N-1:0] rem_s, low_s, q_s, dv_s, rw_s, rh_s;
		afit_ctl_t    cc_s;
		logic [N:0]   trial;
		logic [N:0]   diff;
		logic         ge;

		assign en[g] = !v_s || en[g+1];

		// Shift in the next dividend bit and try the subtract
		assign trial = {rem[g], low[g][N-1]};
		assign diff  = trial - {1'b0, dv[g]};
		assign ge    = trial >= {1'b0, dv[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else if (en[g]) begin
				v_s <= v[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en[g] && v[g]) begin
				rem_s <= ge ? diff[N-1:0] : trial[N-1:0];
				low_s <= {low[g][N-2:0], 1'b0};
				q_s   <= {q[g][N-2:0], ge};
				dv_s  <= dv[g];
				rw_s  <= rw[g];
				rh_s  <= rh[g];
				cc_s  <= cc[g];
			end
		end

		assign v[g+1]   = v_s;
		assign rem[g+1] = rem_s;
		assign low[g+1] = low_s;
		assign q[g+1]   = q_s;
		assign dv[g+1]  = dv_s;
		assign rw[g+1]  = rw_s;
		assign rh[g+1]  = rh_s;
		assign cc[g+1]  = cc_s;
	end

	assign up_ready = en[0];
	assign dn_valid = v[N];
	assign quo      = q[N];
	assign rw_out   = rw[N];
	assign rh_out   = rh[N];
	assign ctl_out  = cc[N];

endmodule
